>>> design/circle_rasterizer_core_assert.svh
// ----------------------------------------------------------------------------
// Circle rasterizer assertion macros
// Shared property shapes for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_RASTERIZER_CORE_ASSERT_SVH
`define CIRCLE_RASTERIZER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/crc_pkg.sv
// ----------------------------------------------------------------------------
// Circle rasterizer package
// Widths, codes and transfer types shared by the circle rasterizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package crc_pkg;

   localparam int COORD_W             = 16;
   localparam int RADIUS_W            = 12;
   localparam int DEC_W               = 24;
   localparam int RADIUS_BITS_DEFAULT = 12;
   localparam int CSR_INDEX_W         = 1;
   localparam int POINT_INDEX_W       = 3;

   localparam logic [COORD_W-1:0] DISPLAY_WIDTH_RESET  = 16'd240;
   localparam logic [COORD_W-1:0] DISPLAY_HEIGHT_RESET = 16'd320;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_HEIGHT = 1'b1;

   localparam logic MODE_START    = 1'b0;
   localparam logic MODE_CONTINUE = 1'b1;

   localparam logic [POINT_INDEX_W-1:0] LAST_POINT = 3'd7;

   typedef struct packed {
      logic                mode;
      logic [COORD_W-1:0]  center_x;
      logic [COORD_W-1:0]  center_y;
      logic [RADIUS_W-1:0] radius;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic               point_valid;
      logic               point_visible;
      logic               last_of_step;
      logic               circle_done;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic               done;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [COORD_W-1:0] off_x;
      logic [COORD_W-1:0] off_y;
   } step_type;

endpackage

`default_nettype wire

>>> design/crc_step.sv
// ----------------------------------------------------------------------------
// Circle rasterizer step unit
// Holds the circle state, advances the midpoint decision on each transfer
// and registers the offsets of the current step for the point emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_step #(
   parameter int RADIUS_BITS = crc_pkg::RADIUS_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire crc_pkg::req_type  req,
   input  wire logic              pop,
   output crc_pkg::step_type      rec,
   output logic                   rec_valid
);

   localparam int RW = RADIUS_BITS + 1;

   logic [crc_pkg::COORD_W-1:0] cx_ff, cx_in;
   logic [crc_pkg::COORD_W-1:0] cy_ff, cy_in;
   logic [RW-1:0]               x_ff, x_in;
   logic [RW-1:0]               y_ff, y_in;
   logic [crc_pkg::DEC_W-1:0]   d_ff, d_in;
   logic                        active_ff, active_in;
   crc_pkg::step_type           rec_ff, rec_in;
   logic                        rec_valid_ff, rec_valid_in;

   logic [crc_pkg::COORD_W-1:0] rad16;
   logic [RW-1:0]               r;
   logic                        start;
   logic                        live;
   logic [crc_pkg::COORD_W-1:0] cx_cur, cy_cur;
   logic [RW-1:0]               x_cur, y_cur;
   logic [crc_pkg::DEC_W-1:0]   d_cur, x24, y24, d_next;
   logic                        neg;
   logic                        done;
   logic [RW:0]                 x_inc;

   always_comb begin
      rad16  = crc_pkg::COORD_W'(req.radius);
      r      = {1'b0, rad16[RADIUS_BITS-1:0]};
      start  = (req.mode == crc_pkg::MODE_START);
      live   = start || active_ff;
      cx_cur = start ? req.center_x : cx_ff;
      cy_cur = start ? req.center_y : cy_ff;
      x_cur  = start ? '0 : x_ff;
      y_cur  = start ? r : y_ff;
      d_cur  = start ? (crc_pkg::DEC_W'(3) - (crc_pkg::DEC_W'(r) << 1)) : d_ff;
      neg    = d_cur[crc_pkg::DEC_W-1];
      x24    = crc_pkg::DEC_W'(x_cur);
      y24    = crc_pkg::DEC_W'(y_cur);
      x_inc  = {1'b0, x_cur} + (RW+1)'(1);
      if (neg) begin
         d_next = d_cur + (x24 << 2) + crc_pkg::DEC_W'(6);
         done   = (x_cur >= y_cur);
      end else begin
         d_next = d_cur + ((x24 - y24) << 2) + crc_pkg::DEC_W'(10);
         done   = (x_inc >= {1'b0, y_cur});
      end
   end

   always_comb begin
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      d_in         = d_ff;
      active_in    = active_ff;
      rec_in       = rec_ff;
      rec_valid_in = rec_valid_ff && !pop;
      if (accept) begin
         rec_valid_in = 1'b1;
         rec_in.valid = live;
         rec_in.done  = done || !live;
         rec_in.cx    = cx_cur;
         rec_in.cy    = cy_cur;
         rec_in.off_x = crc_pkg::COORD_W'(x_cur);
         rec_in.off_y = crc_pkg::COORD_W'(y_cur);
         if (live) begin
            cx_in     = cx_cur;
            cy_in     = cy_cur;
            d_in      = d_next;
            active_in = !done;
            if (!done) begin
               x_in = x_inc[RW-1:0];
               y_in = neg ? y_cur : (y_cur - RW'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff        <= '0;
         cy_ff        <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         d_ff         <= '0;
         active_ff    <= 1'b0;
         rec_valid_ff <= 1'b0;
      end else begin
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         d_ff         <= d_in;
         active_ff    <= active_in;
         rec_valid_ff <= rec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec       = rec_ff;
   assign rec_valid = rec_valid_ff;

endmodule

`default_nettype wire

>>> design/crc_emit.sv
// ----------------------------------------------------------------------------
// Circle rasterizer point emitter
// Walks the eight symmetric points of a step, flags visibility and drives
// the registered result channel one point per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_emit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire crc_pkg::step_type           rec,
   input  wire logic                        rec_valid,
   input  wire logic [crc_pkg::COORD_W-1:0] display_width,
   input  wire logic [crc_pkg::COORD_W-1:0] display_height,
   input  wire logic                        rsp_stall,
   output logic                             pop,
   output logic                             rsp_valid,
   output crc_pkg::rsp_type                 rsp_payload
);

   logic [crc_pkg::POINT_INDEX_W-1:0] idx_ff, idx_in;
   logic                              out_valid_ff, out_valid_in;
   crc_pkg::rsp_type                  out_ff, out_in;

   logic                        load;
   logic                        last;
   logic [crc_pkg::COORD_W-1:0] a, b, px, py;
   crc_pkg::rsp_type            point;

   always_comb begin
      a    = idx_ff[1] ? rec.off_y : rec.off_x;
      b    = idx_ff[1] ? rec.off_x : rec.off_y;
      px   = idx_ff[0] ? (rec.cx - a) : (rec.cx + a);
      py   = idx_ff[2] ? (rec.cy + b) : (rec.cy - b);
      last = !rec.valid || (idx_ff == crc_pkg::LAST_POINT);
      if (rec.valid) begin
         point.point_x       = px;
         point.point_y       = py;
         point.point_valid   = 1'b1;
         point.point_visible = (px < display_width) && (py < display_height);
      end else begin
         point.point_x       = '0;
         point.point_y       = '0;
         point.point_valid   = 1'b0;
         point.point_visible = 1'b0;
      end
      point.last_of_step = last;
      point.circle_done  = rec.done;
   end

   always_comb begin
      load         = rec_valid && (!out_valid_ff || !rsp_stall);
      pop          = load && last;
      idx_in       = idx_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (load) begin
         out_in       = point;
         out_valid_in = 1'b1;
         idx_in       = last ? '0 : (idx_ff + crc_pkg::POINT_INDEX_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

>>> design/circle_rasterizer_core.sv
// The step of an accepted request is registered in the step buffer, and its
// points then in the result register, one per cycle while rsp_stall is low.
// Each step gives eight points, one for a continue with no circle, a single
// point per transfer; a new request is taken as the step's last point loads.
// Reset: synchronous; no circle active, display 240 by 320.
// ----------------------------------------------------------------------------
// Circle rasterizer core
// Midpoint circle generator: a step unit with one buffered step feeding a
// point emitter, plus the display size registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circle_rasterizer_core_assert.svh"

module circle_rasterizer_core #(
   parameter int RADIUS_BITS = crc_pkg::RADIUS_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire crc_pkg::req_type               req_payload,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output crc_pkg::rsp_type                    rsp_payload,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [crc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [crc_pkg::COORD_W-1:0]    csr_data
);

   logic [crc_pkg::COORD_W-1:0] width_ff, width_in;
   logic [crc_pkg::COORD_W-1:0] height_ff, height_in;

   logic              accept;
   logic              pop;
   logic              rec_valid;
   crc_pkg::step_type rec;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            crc_pkg::CSR_DISPLAY_WIDTH:  width_in  = csr_data;
            crc_pkg::CSR_DISPLAY_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= crc_pkg::DISPLAY_WIDTH_RESET;
         height_ff <= crc_pkg::DISPLAY_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign req_stall = rec_valid && !pop;
   assign accept    = req_valid && !req_stall;

   crc_step #(
      .RADIUS_BITS(RADIUS_BITS)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .pop       (pop),
      .rec       (rec),
      .rec_valid (rec_valid)
   );

   crc_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .rec            (rec),
      .rec_valid      (rec_valid),
      .display_width  (width_ff),
      .display_height (height_ff),
      .rsp_stall      (rsp_stall),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload)
   );

   `CRC_ASSERT_SAME(a_invalid_point_ends_step, clock, reset,
      rsp_valid && !rsp_payload.point_valid,
      rsp_payload.last_of_step && rsp_payload.circle_done && !rsp_payload.point_visible,
      "invalid point must be the last and final result of its step")

   `CRC_ASSERT_NEXT(a_step_held_until_last, clock, reset,
      rsp_valid && !rsp_stall && !rsp_payload.last_of_step,
      rec_valid || (rsp_valid && rsp_payload.last_of_step),
      "step buffer released before its last point")

   `CRC_ASSERT_SAME(a_stall_when_step_held, clock, reset,
      rec_valid && !pop,
      req_stall,
      "request taken while the step buffer is still occupied")

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circle rasterizer core testbench
// Drives start and continue requests through the request channel, predicts
// the eight symmetric points of every midpoint circle step in the bench, and
// checks each point transfer against the oldest prediction. The display size
// registers are rewritten between test groups, and both channels idle at
// random with two different idling patterns, plus a round with no idling.
// ----------------------------------------------------------------------------
module testbench;
   import crc_pkg::*;

   localparam int RADIUS_BITS = RADIUS_BITS_DEFAULT;
   localparam int ROUND_ITEMS = 52;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_MAX = 10;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0]     csr_data = '0;

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   logic [COORD_W-1:0] disp_width = DISPLAY_WIDTH_RESET;
   logic [COORD_W-1:0] disp_height = DISPLAY_HEIGHT_RESET;
   logic [COORD_W-1:0] arc_col = '0;
   logic [COORD_W-1:0] arc_row = '0;
   int                 arc_x = 0;
   int                 arc_y = 0;
   logic signed [DEC_W-1:0] arc_decision = '0;
   logic               arc_active = 1'b0;

   rsp_type expected_points[$];

   circle_rasterizer_core #(.RADIUS_BITS(RADIUS_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   function automatic void advance_arc(input req_type item);
      logic [COORD_W-1:0] cx, cy, xo, yo;
      logic [COORD_W-1:0] px [8];
      logic [COORD_W-1:0] py [8];
      longint d;
      int nx, ny, k;
      logic done;
      rsp_type pt;
      if (item.mode == MODE_START) begin
         arc_col = item.center_x;
         arc_row = item.center_y;
         arc_x = 0;
         arc_y = int'(item.radius) & ((1 << RADIUS_BITS) - 1);
         arc_decision = DEC_W'(3 - 2 * arc_y);
         arc_active = 1'b1;
      end else if (!arc_active) begin
         pt = '0;
         pt.last_of_step = 1'b1;
         pt.circle_done = 1'b1;
         expected_points.push_back(pt);
         return;
      end
      d = longint'(arc_decision);
      nx = arc_x + 1;
      ny = arc_y;
      if (d < 0) begin
         d += 4 * arc_x + 6;
      end else begin
         d += 4 * (arc_x - arc_y) + 10;
         ny -= 1;
      end
      done = (nx > ny);
      cx = arc_col;
      cy = arc_row;
      xo = COORD_W'(arc_x);
      yo = COORD_W'(arc_y);
      px = '{cx + xo, cx - xo, cx + yo, cx - yo, cx + xo, cx - xo, cx + yo, cx - yo};
      py = '{cy - yo, cy - yo, cy - xo, cy - xo, cy + yo, cy + yo, cy + xo, cy + xo};
      for (k = 0; k < 8; k++) begin
         pt.point_x = px[k];
         pt.point_y = py[k];
         pt.point_valid = 1'b1;
         pt.point_visible = (px[k] < disp_width) && (py[k] < disp_height);
         pt.last_of_step = (k == LAST_POINT);
         pt.circle_done = done;
         expected_points.push_back(pt);
      end
      arc_decision = DEC_W'(d);
      if (done) begin
         arc_active = 1'b0;
      end else begin
         arc_x = nx;
         arc_y = ny;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("Unexpected point x=%0d y=%0d valid=%0b vis=%0b last=%0b done=%0b",
                        rsp_payload.point_x, rsp_payload.point_y, rsp_payload.point_valid,
                        rsp_payload.point_visible, rsp_payload.last_of_step,
                        rsp_payload.circle_done);
         end else begin
            want = expected_points.pop_front();
            if (rsp_payload.point_x !== want.point_x || rsp_payload.point_y !== want.point_y
                || rsp_payload.point_valid !== want.point_valid
                || rsp_payload.point_visible !== want.point_visible
                || rsp_payload.last_of_step !== want.last_of_step
                || rsp_payload.circle_done !== want.circle_done) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("Point mismatch: expected x=%0d y=%0d valid=%0b vis=%0b last=%0b done=%0b, got x=%0d y=%0d valid=%0b vis=%0b last=%0b done=%0b",
                           want.point_x, want.point_y, want.point_valid,
                           want.point_visible, want.last_of_step, want.circle_done,
                           rsp_payload.point_x, rsp_payload.point_y,
                           rsp_payload.point_valid, rsp_payload.point_visible,
                           rsp_payload.last_of_step, rsp_payload.circle_done);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         req_payload.center_x = $urandom_range(0, 65535);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = item;
      do @(posedge clock); while (req_stall);
      advance_arc(item);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_points_drained();
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   task automatic write_display(input logic [CSR_INDEX_W-1:0] idx,
                                input logic [COORD_W-1:0] value);
      wait_points_drained();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DISPLAY_WIDTH)
         disp_width = value;
      else
         disp_height = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic req_type make_request(input logic mode, input int col, input int row,
                                            input int rad);
      req_type item;
      item.mode = mode;
      item.center_x = COORD_W'(col);
      item.center_y = COORD_W'(row);
      item.radius = RADIUS_W'(rad);
      return item;
   endfunction

   function automatic req_type random_continue();
      return make_request(MODE_CONTINUE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 4095));
   endfunction

   task automatic finish_circle();
      while (arc_active) send_request(random_continue());
   endtask

   task automatic test_no_circle();
      send_request(make_request(MODE_CONTINUE, 16'hFFFF, 16'hFFFF, 12'hFFF));
      send_request(make_request(MODE_CONTINUE, 0, 0, 0));
      release_request();
   endtask

   task automatic test_zero_radius();
      send_request(make_request(MODE_START, 0, 0, 0));
      send_request(random_continue());
      send_request(make_request(MODE_START, 16'hFFFF, 16'hFFFF, 0));
      release_request();
   endtask

   task automatic test_restart_and_wrap();
      send_request(make_request(MODE_START, 16'hFFFF, 0, 12'hFFF));
      send_request(random_continue());
      send_request(random_continue());
      send_request(make_request(MODE_START, 0, 16'hFFFF, 12'hFFF));
      send_request(random_continue());
      send_request(make_request(MODE_START, 120, 160, 1));
      finish_circle();
      send_request(make_request(MODE_START, 50, 60, 5));
      finish_circle();
      release_request();
   endtask

   task automatic test_display_limits();
      write_display(CSR_DISPLAY_WIDTH, 16'd0);
      write_display(CSR_DISPLAY_HEIGHT, 16'd0);
      send_request(make_request(MODE_START, 0, 0, 0));
      release_request();
      write_display(CSR_DISPLAY_WIDTH, 16'd1);
      write_display(CSR_DISPLAY_HEIGHT, 16'd1);
      send_request(make_request(MODE_START, 0, 0, 0));
      send_request(make_request(MODE_START, 1, 0, 1));
      release_request();
      write_display(CSR_DISPLAY_WIDTH, 16'hFFFF);
      write_display(CSR_DISPLAY_HEIGHT, 16'hFFFF);
      send_request(make_request(MODE_START, 16'hFFFE, 16'hFFFE, 1));
      send_request(make_request(MODE_START, 16'hFFFF, 16'hFFFF, 0));
      release_request();
      write_display(CSR_DISPLAY_WIDTH, DISPLAY_WIDTH_RESET);
      write_display(CSR_DISPLAY_HEIGHT, DISPLAY_HEIGHT_RESET);
   endtask

   function automatic logic [COORD_W-1:0] random_extent();
      int roll;
      roll = $urandom_range(99);
      if (roll < 25)
         return 16'hFFFF;
      else if (roll < 60)
         return COORD_W'($urandom_range(1, 400));
      return COORD_W'($urandom_range(0, 65535));
   endfunction

   task automatic test_random_circles(input int sender_pct, input int receiver_pct);
      int sent, roll, steps_left;
      req_type item;
      write_display(CSR_DISPLAY_WIDTH, random_extent());
      write_display(CSR_DISPLAY_HEIGHT, random_extent());
      sender_idle_pct = sender_pct;
      receiver_idle_pct = receiver_pct;
      sent = 0;
      while (sent < ROUND_ITEMS) begin
         roll = $urandom_range(99);
         item = random_continue();
         if (roll < 10) begin
            send_request(item);
            sent++;
         end else begin
            item.mode = MODE_START;
            if (roll < 25) begin
               steps_left = $urandom_range(0, 4);
            end else begin
               item.radius = RADIUS_W'($urandom_range(0, 24));
               steps_left = (roll < 35) ? $urandom_range(0, 3) : 1000;
            end
            if (roll >= 50) begin
               item.center_x = COORD_W'($urandom_range(0, 420));
               item.center_y = COORD_W'($urandom_range(0, 420));
            end
            send_request(item);
            sent++;
            while (arc_active && steps_left > 0) begin
               send_request(random_continue());
               sent++;
               steps_left--;
            end
         end
      end
      release_request();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      sender_idle_pct = 33;
      receiver_idle_pct = 47;
      test_no_circle();
      test_zero_radius();
      test_restart_and_wrap();
      test_display_limits();
      test_random_circles(33, 47);
      test_random_circles(47, 33);
      test_random_circles(0, 0);
      wait_points_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_points.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> circle_rasterizer_core.f
+incdir+design
design/crc_pkg.sv
design/crc_step.sv
design/crc_emit.sv
design/circle_rasterizer_core.sv
sim/testbench.sv
